// File: sv/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

	localparam int RAM_BYTES = 32768;
	localparam int RAM_AW = $clog2(RAM_BYTES);
	localparam int RAM_IDX_W = 15;

	localparam logic OP_READ = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] KIND_ROM = 2'd0;
	localparam logic [1:0] KIND_RAM = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic [2:0] RBB_RESET = 3'd7;
	localparam logic [7:0] RAM_EN_KEY = 8'h0A;
	localparam logic [7:0] RAM_OFF_DATA = 8'hFF;

	typedef struct packed {
		logic op;
		logic [15:0] bus_address;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [20:0] rom_offset;
		logic [7:0] read_data;
	} rsp_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic [RAM_AW-1:0] addr;
		logic [7:0] wdata;
	} ram_req_t;

endpackage

// File: sv/cbm_ram.sv
// External RAM with registered read and a clearing pass after reset.
module cbm_ram (
	input  logic clk,
	input  logic arst_n,
	input  cbm_pkg::ram_req_t req,
	output logic [7:0] rd_data,
	output logic busy
);

	logic [7:0] mem [cbm_pkg::RAM_BYTES];
	logic [cbm_pkg::RAM_AW:0] clr_cnt_q;
	logic [7:0] rd_data_q;

	assign busy = ~clr_cnt_q[cbm_pkg::RAM_AW];
	assign rd_data = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (busy) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_cnt_q[cbm_pkg::RAM_AW-1:0]] <= '0;
		end else if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.addr];
		end
	end

endmodule

// File: sv/cartridge_bank_mapper_top.sv
// Top level of the cartridge bank mapper: decode, bank registers, RAM and output stage.
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one CPU bus access per
//   transfer: op, bus_address, write_data. Output channel (out_valid / out_stall /
//   out_data) returns exactly one result per access, in order: kind, rom_offset,
//   read_data.
//   Throughput is one access per cycle while in_stall is low. Each result passes
//   through the RAM read stage (synchronous RAM read) and the output register.
//   Bank registers and RAM writes take effect at the input transfer, so the very
//   next access already sees them.
//   cfg_wr_en / cfg_wr_data write rom_bank_bits (reset 7); write only while idle.
//   After reset the RAM is zeroed by a clearing pass over all RAM_BYTES addresses
//   (32768 with the default size); in_stall stays high during the pass.
//   When the receiver stalls, the output register holds its result and one more
//   access can still be taken into the RAM read stage before in_stall rises.
module cartridge_bank_mapper_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  logic in_valid,
	output logic in_stall,
	input  cbm_pkg::req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output cbm_pkg::rsp_t out_data
);

	localparam logic [2:0] RGN_RAM_EN = 3'd0;
	localparam logic [2:0] RGN_LOW = 3'd1;
	localparam logic [2:0] RGN_HIGH = 3'd2;
	localparam logic [2:0] RGN_MODE = 3'd3;
	localparam logic [2:0] RGN_RAM = 3'd5;

	logic [2:0] rbb_q;
	logic [7:0] low_bank_q;
	logic [1:0] high_bank_q;
	logic ram_mode_q;
	logic ram_en_q;

	logic s1_valid_q;
	logic [1:0] kind_s1;
	logic [20:0] offset_s1;
	logic ram_rd_s1;
	logic ram_en_s1;

	logic out_valid_q;
	cbm_pkg::rsp_t out_q;

	logic acc;
	logic s1_adv;
	logic ram_busy;
	logic [7:0] ram_rd_data;
	cbm_pkg::ram_req_t ram_req;

	logic [2:0] rgn;
	logic in_ram_win;
	logic [7:0] bank_lo;
	logic [8:0] bank_sum;
	logic [8:0] bank_mask;
	logic [8:0] bank_m;
	logic [1:0] ram_bank;
	logic [cbm_pkg::RAM_IDX_W-1:0] ram_idx;
	logic [1:0] kind_n;
	logic [20:0] offset_n;

	assign s1_adv = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = ram_busy || (s1_valid_q && !s1_adv);
	assign acc = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign rgn = in_data.bus_address[15:13];
	assign in_ram_win = (rgn == RGN_RAM);

	always_comb begin
		bank_lo = (low_bank_q == 8'd0) ? 8'd1 : low_bank_q;
		bank_sum = {1'b0, bank_lo};
		if (!ram_mode_q) begin
			bank_sum = {1'b0, bank_lo} + {2'b00, high_bank_q, 5'd0};
		end
		bank_mask = (9'd1 << rbb_q) - 9'd1;
		bank_m = bank_sum & bank_mask;
		ram_bank = ram_mode_q ? high_bank_q : 2'd0;
		ram_idx = {ram_bank, in_data.bus_address[12:0]};

		kind_n = cbm_pkg::KIND_NONE;
		offset_n = '0;
		if (in_data.op == cbm_pkg::OP_READ) begin
			if (in_data.bus_address[15:14] == 2'd0) begin
				kind_n = cbm_pkg::KIND_ROM;
				offset_n = {7'd0, in_data.bus_address[13:0]};
			end else if (in_data.bus_address[15:14] == 2'd1) begin
				kind_n = cbm_pkg::KIND_ROM;
				offset_n = {bank_m[6:0], in_data.bus_address[13:0]};
			end else if (in_ram_win) begin
				kind_n = cbm_pkg::KIND_RAM;
			end
		end else if (rgn == RGN_RAM_EN || rgn == RGN_LOW || rgn == RGN_HIGH
				|| rgn == RGN_MODE || in_ram_win) begin
			kind_n = cbm_pkg::KIND_WRITE;
		end

		ram_req.addr = ram_idx[cbm_pkg::RAM_AW-1:0];
		ram_req.wdata = in_data.write_data;
		ram_req.rd_en = acc && (in_data.op == cbm_pkg::OP_READ) && in_ram_win && ram_en_q;
		ram_req.wr_en = acc && (in_data.op == cbm_pkg::OP_WRITE) && in_ram_win && ram_en_q;
	end

	cbm_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_data (ram_rd_data),
		.busy    (ram_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbb_q <= cbm_pkg::RBB_RESET;
			low_bank_q <= 8'd1;
			high_bank_q <= 2'd0;
			ram_mode_q <= 1'b0;
			ram_en_q <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				rbb_q <= cfg_wr_data;
			end
			if (acc && in_data.op == cbm_pkg::OP_WRITE) begin
				unique case (rgn)
					RGN_RAM_EN: ram_en_q <= (in_data.write_data == cbm_pkg::RAM_EN_KEY);
					RGN_LOW: low_bank_q <= in_data.write_data;
					RGN_HIGH: high_bank_q <= in_data.write_data[1:0];
					RGN_MODE: ram_mode_q <= in_data.write_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_s1 <= kind_n;
			offset_s1 <= offset_n;
			ram_rd_s1 <= (kind_n == cbm_pkg::KIND_RAM);
			ram_en_s1 <= ram_en_q;
		end
		if (s1_adv) begin
			out_q.kind <= kind_s1;
			out_q.rom_offset <= offset_s1;
			if (!ram_rd_s1) begin
				out_q.read_data <= 8'd0;
			end else if (ram_en_s1) begin
				out_q.read_data <= ram_rd_data;
			end else begin
				out_q.read_data <= cbm_pkg::RAM_OFF_DATA;
			end
		end
	end

endmodule

// File: sv/cbm_checker.sv
// Port-level checker for the cartridge bank mapper and its bind.
module cbm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input cbm_pkg::rsp_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output transfer changed");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("result missing two cycles after input transfer");

	a_rom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != cbm_pkg::KIND_ROM |-> out_data.rom_offset == 21'd0)
		else $error("rom_offset nonzero on a non-ROM result");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != cbm_pkg::KIND_RAM |-> out_data.read_data == 8'd0)
		else $error("read_data nonzero on a non-RAM result");

endmodule

bind cartridge_bank_mapper_top cbm_checker u_cbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
